>>> hw/rtl/clipped_line_rect_span_gen_top_macros.svh
// Assertion macros for the span generator.
// Used by the top level only; needs nothing else.
`ifndef CLIPPED_LINE_RECT_SPAN_GEN_TOP_MACROS_SVH
`define CLIPPED_LINE_RECT_SPAN_GEN_TOP_MACROS_SVH

// same-cycle implication
`define CLRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("span generator check failed");

// next-cycle implication
`define CLRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("span generator check failed");

`endif

>>> hw/rtl/clrs_pkg.sv
// Shared types, constants and clip helpers for the span generator.
// No dependencies.
package clrs_pkg;

	localparam int COORD_BITS = 16;
	localparam int MAX_DIM    = 4096;
	localparam int DIM_REG_W  = 13;
	localparam int PITCH_W    = 14;
	localparam int CNT_W      = 13;
	localparam int ADDR_W     = 25;
	localparam int COLOR_W    = 32;
	localparam int CFG_W      = (COORD_BITS > PITCH_W) ? COORD_BITS : PITCH_W;
	localparam int CFG_IDX_W  = 3;
	localparam int DIM_BITS   = $clog2(MAX_DIM) + 1;
	// internal signed width: holds a coordinate plus an extent and their difference
	localparam int CW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 3;
	localparam int NUM_RUNS   = 4;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);

	localparam logic signed [CW-1:0] C_ONE  = CW'(1);
	localparam logic signed [CW-1:0] C_ZERO = '0;

	localparam logic [DIM_REG_W-1:0] RST_SCREEN_W = DIM_REG_W'(640);
	localparam logic [DIM_REG_W-1:0] RST_SCREEN_H = DIM_REG_W'(480);
	localparam logic [PITCH_W-1:0]   RST_PITCH    = PITCH_W'(640);
	localparam logic [COORD_BITS-1:0] RST_CLIP_X  = '0;
	localparam logic [COORD_BITS-1:0] RST_CLIP_Y  = '0;
	localparam logic [DIM_REG_W-1:0] RST_CLIP_W   = DIM_REG_W'(640);
	localparam logic [DIM_REG_W-1:0] RST_CLIP_H   = DIM_REG_W'(480);

	typedef enum logic [1:0] {
		CMD_HLINE   = 2'd0,
		CMD_VLINE   = 2'd1,
		CMD_OUTLINE = 2'd2,
		CMD_FILL    = 2'd3
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_W = 3'd0,
		CFG_SCREEN_H = 3'd1,
		CFG_PITCH    = 3'd2,
		CFG_CLIP_X   = 3'd3,
		CFG_CLIP_Y   = 3'd4,
		CFG_CLIP_W   = 3'd5,
		CFG_CLIP_H   = 3'd6
	} cfg_idx_e;

	typedef struct packed {
		cmd_e                         cmd;
		logic                         use_clip;
		logic signed [COORD_BITS-1:0] x_pos;
		logic signed [COORD_BITS-1:0] y_pos;
		logic signed [COORD_BITS-1:0] span_w;
		logic signed [COORD_BITS-1:0] span_h;
		logic [COLOR_W-1:0]           color;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  start_addr;
		logic [CNT_W-1:0]   run_cols;
		logic [CNT_W-1:0]   run_rows;
		logic [COLOR_W-1:0] pix_value;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [DIM_REG_W-1:0]         screen_w;
		logic [DIM_REG_W-1:0]         screen_h;
		logic signed [COORD_BITS-1:0] clip_x;
		logic signed [COORD_BITS-1:0] clip_y;
		logic [DIM_REG_W-1:0]         clip_w;
		logic [DIM_REG_W-1:0]         clip_h;
	} cfg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] w;
		logic signed [CW-1:0] h;
	} win_t;

	typedef struct packed {
		logic signed [CW-1:0] start;
		logic signed [CW-1:0] len;
	} span_t;

	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic [CNT_W-1:0]     cols;
		logic [CNT_W-1:0]     rows;
	} run_t;

	// one classified command: up to four clipped runs, mask marks the live ones
	typedef struct packed {
		run_t [NUM_RUNS-1:0] runs;
		logic [NUM_RUNS-1:0] mask;
		logic [COLOR_W-1:0]  color;
	} q_entry_t;

	function automatic logic signed [CW-1:0] sat_dim(input logic [DIM_REG_W-1:0] v);
		logic [CW-1:0] ve;
		ve = CW'(v);
		if (ve > CW'(MAX_DIM))
			ve = CW'(MAX_DIM);
		return signed'(ve);
	endfunction

	// intersect [a, a+len) with [lo, lo+size); len of result <= 0 when empty
	function automatic span_t clip_span(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] len, input logic signed [CW-1:0] lo,
			input logic signed [CW-1:0] size);
		span_t r;
		logic signed [CW-1:0] e1;
		logic signed [CW-1:0] e2;
		logic signed [CW-1:0] e;
		r.start = (a > lo) ? a : lo;
		e1 = a + len;
		e2 = lo + size;
		e = (e1 < e2) ? e1 : e2;
		r.len = e - r.start;
		return r;
	endfunction

endpackage

>>> hw/rtl/clrs_front.sv
// Front end: input register, window selection and clipping into up to four runs.
// Depends on clrs_pkg.
module clrs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  clrs_pkg::in_item_t in_data,
	input  clrs_pkg::cfg_t    cfg,
	output logic              q_push,
	output clrs_pkg::q_entry_t q_entry,
	input  logic              q_full
);
	import clrs_pkg::*;

	logic                 vld_s1;
	cmd_e                 cmd_s1;
	logic                 pos_s1;
	logic signed [CW-1:0] x_s1, y_s1, w_s1, h_s1, xr_s1, yb_s1;
	win_t                 win_s1;
	logic [COLOR_W-1:0]   color_s1;

	logic                 accept;
	logic signed [CW-1:0] x_in, y_in, w_in, h_in;
	win_t                 win_in;

	logic signed [CW-1:0] ax [NUM_RUNS];
	logic signed [CW-1:0] lx [NUM_RUNS];
	logic signed [CW-1:0] ay [NUM_RUNS];
	logic signed [CW-1:0] ly [NUM_RUNS];
	logic [NUM_RUNS-1:0]  en;
	span_t                spx [NUM_RUNS];
	span_t                spy [NUM_RUNS];

	assign in_stall = vld_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = vld_s1 && !q_full;

	always_comb begin
		x_in = CW'(in_data.x_pos);
		y_in = CW'(in_data.y_pos);
		w_in = CW'(in_data.span_w);
		h_in = CW'(in_data.span_h);
		// fill always uses the screen
		if (in_data.cmd == CMD_FILL || !in_data.use_clip) begin
			win_in.x = C_ZERO;
			win_in.y = C_ZERO;
			win_in.w = sat_dim(cfg.screen_w);
			win_in.h = sat_dim(cfg.screen_h);
		end else begin
			win_in.x = CW'(cfg.clip_x);
			win_in.y = CW'(cfg.clip_y);
			win_in.w = sat_dim(cfg.clip_w);
			win_in.h = sat_dim(cfg.clip_h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= in_data.cmd;
			pos_s1   <= (w_in > C_ZERO) && (h_in > C_ZERO);
			x_s1     <= x_in;
			y_s1     <= y_in;
			w_s1     <= w_in;
			h_s1     <= h_in;
			xr_s1    <= x_in + w_in - C_ONE;
			yb_s1    <= y_in + h_in - C_ONE;
			win_s1   <= win_in;
			color_s1 <= in_data.color;
		end
	end

	// slot order for an outline: top, bottom, left, right
	always_comb begin
		ax[0] = x_s1;  lx[0] = w_s1;  ay[0] = y_s1;  ly[0] = C_ONE;
		ax[1] = x_s1;  lx[1] = w_s1;  ay[1] = yb_s1; ly[1] = C_ONE;
		ax[2] = x_s1;  lx[2] = C_ONE; ay[2] = y_s1;  ly[2] = h_s1;
		ax[3] = xr_s1; lx[3] = C_ONE; ay[3] = y_s1;  ly[3] = h_s1;
		en = '0;
		unique case (cmd_s1)
			CMD_HLINE: begin
				en[0] = 1'b1;
			end
			CMD_VLINE: begin
				lx[0] = C_ONE;
				ly[0] = h_s1;
				en[0] = 1'b1;
			end
			CMD_OUTLINE: begin
				en = {NUM_RUNS{pos_s1}};
			end
			CMD_FILL: begin
				ly[0] = h_s1;
				en[0] = pos_s1;
			end
			default: begin
				en = '0;
			end
		endcase
	end

	always_comb begin
		q_entry.color = color_s1;
		for (int i = 0; i < NUM_RUNS; i++) begin
			spx[i] = clip_span(ax[i], lx[i], win_s1.x, win_s1.w);
			spy[i] = clip_span(ay[i], ly[i], win_s1.y, win_s1.h);
			q_entry.runs[i].sx   = spx[i].start;
			q_entry.runs[i].sy   = spy[i].start;
			q_entry.runs[i].cols = spx[i].len[CNT_W-1:0];
			q_entry.runs[i].rows = spy[i].len[CNT_W-1:0];
			q_entry.mask[i] = en[i] && (spx[i].len > C_ZERO) && (spy[i].len > C_ZERO);
		end
	end

endmodule

>>> hw/rtl/clrs_fifo.sv
// Short queue of classified commands between front and back end.
// Depends on clrs_pkg.
module clrs_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  clrs_pkg::q_entry_t push_data,
	input  logic               pop,
	output clrs_pkg::q_entry_t head,
	output logic               full,
	output logic               empty
);
	import clrs_pkg::*;

	q_entry_t        entries_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full  = count_q == (Q_AW+1)'(Q_DEPTH);
	assign empty = count_q == '0;
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (push && !pop)
				count_q <= count_q + (Q_AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (Q_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> hw/rtl/clrs_back.sv
// Back end: walks the head's runs into the output register, one per cycle unless stalled.
// Depends on clrs_pkg.
module clrs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  clrs_pkg::q_entry_t    head,
	input  logic                  q_empty,
	output logic                  pop,
	input  logic [clrs_pkg::PITCH_W-1:0] pitch,
	output logic                  out_valid,
	input  logic                  out_stall,
	output clrs_pkg::out_item_t   out_data
);
	import clrs_pkg::*;

	localparam int PROD_W = CW + PITCH_W + 1;

	logic [NUM_RUNS-1:0]     taken_q;
	logic                    out_valid_q;
	out_item_t               out_data_q;

	logic [NUM_RUNS-1:0]     rem;
	logic [NUM_RUNS-1:0]     pick;
	logic [NUM_RUNS-1:0]     more;
	logic                    load_ok;
	logic                    emit;
	run_t                    sel;
	logic signed [PROD_W-1:0] addr_full;

	assign rem     = head.mask & ~taken_q;
	assign pick    = rem & (~rem + NUM_RUNS'(1));
	assign more    = rem & ~pick;
	assign load_ok = !out_valid_q || !out_stall;
	assign emit    = !q_empty && (rem != '0) && load_ok;
	// a command with nothing left (or nothing at all) leaves the queue
	assign pop     = !q_empty && ((rem == '0) || (emit && more == '0));

	always_comb begin
		sel = '0;
		for (int i = 0; i < NUM_RUNS; i++) begin
			if (pick[i])
				sel = head.runs[i];
		end
		addr_full = sel.sy * $signed({1'b0, pitch}) + PROD_W'(sel.sx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				taken_q <= '0;
			else if (emit)
				taken_q <= taken_q | pick;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.start_addr <= addr_full[ADDR_W-1:0];
			out_data_q.run_cols   <= sel.cols;
			out_data_q.run_rows   <= sel.rows;
			out_data_q.pix_value  <= head.color;
			out_data_q.last       <= (more == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> hw/rtl/clipped_line_rect_span_gen_top.sv
// Clipped line / rectangle span generator. Each accepted command (hline, vline,
// rectangle outline, filled rectangle) is registered and clipped in the front end,
// queued (four deep), and turned by the back end into write descriptors, one per
// cycle while the output is not stalled: hlines, vlines and fills give one, an
// outline one per visible side (up to four), and a command clipped away entirely
// leaves the queue with no output. The back end's single output register sets the
// throughput. A result passes the input register, queue and output register.
// Depends on clrs_pkg, clrs_front, clrs_fifo, clrs_back and the macros header.
`include "clipped_line_rect_span_gen_top_macros.svh"

module clipped_line_rect_span_gen_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  clrs_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output clrs_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [clrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [clrs_pkg::CFG_W-1:0]      cfg_wdata
);
	import clrs_pkg::*;

	cfg_t               cfg_q;
	logic [PITCH_W-1:0] pitch_q;

	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	q_entry_t q_in;
	q_entry_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_w <= RST_SCREEN_W;
			cfg_q.screen_h <= RST_SCREEN_H;
			pitch_q        <= RST_PITCH;
			cfg_q.clip_x   <= RST_CLIP_X;
			cfg_q.clip_y   <= RST_CLIP_Y;
			cfg_q.clip_w   <= RST_CLIP_W;
			cfg_q.clip_h   <= RST_CLIP_H;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SCREEN_W: cfg_q.screen_w <= cfg_wdata[DIM_REG_W-1:0];
				CFG_SCREEN_H: cfg_q.screen_h <= cfg_wdata[DIM_REG_W-1:0];
				CFG_PITCH:    pitch_q        <= cfg_wdata[PITCH_W-1:0];
				CFG_CLIP_X:   cfg_q.clip_x   <= cfg_wdata[COORD_BITS-1:0];
				CFG_CLIP_Y:   cfg_q.clip_y   <= cfg_wdata[COORD_BITS-1:0];
				CFG_CLIP_W:   cfg_q.clip_w   <= cfg_wdata[DIM_REG_W-1:0];
				CFG_CLIP_H:   cfg_q.clip_h   <= cfg_wdata[DIM_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	clrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_push   (q_push),
		.q_entry  (q_in),
		.q_full   (q_full)
	);

	clrs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	clrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.pitch     (pitch_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// every emitted run covers at least one pixel
	`CLRS_ASSERT_IMPL(a_run_nonempty, clk, arst_n, out_valid,
		(out_data.run_cols != '0) && (out_data.run_rows != '0))
	// runs of one command follow each other without a gap
	`CLRS_ASSERT_NEXT(a_runs_contiguous, clk, arst_n,
		out_valid && !out_stall && !out_data.last, out_valid)
	// the back end never takes from an empty queue
	`CLRS_ASSERT_IMPL(a_no_underflow, clk, arst_n, q_pop, !q_empty)

endmodule

>>> tb/clrs_span_checker.sv
// Scoreboard for the span generator: watches the command, result and register ports,
// predicts the clipped runs of every accepted command and compares them in order.
// Depends on clrs_pkg only.
module clrs_span_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  clrs_pkg::in_item_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  clrs_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [clrs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [clrs_pkg::CFG_W-1:0]     cfg_wdata,
	output int                             fail_count,
	output int                             runs_pending,
	output int                             runs_seen
);
	import clrs_pkg::*;

	out_item_t span_fifo [$];

	// shadow copy of the register file, raw widths
	longint scr_w, scr_h, pitch, win_x, win_y, win_w, win_h;

	function automatic longint sat_dim4k(input longint v);
		return (v > MAX_DIM) ? longint'(MAX_DIM) : v;
	endfunction

	// [a, a+len) against [lo, lo+size): length of the overlap, <= 0 when empty
	function automatic longint overlap(input longint a, len, lo, size, output longint first);
		longint stop_a, stop_b;
		first = (a > lo) ? a : lo;
		stop_a = a + len;
		stop_b = lo + size;
		return ((stop_a < stop_b) ? stop_a : stop_b) - first;
	endfunction

	function automatic out_item_t make_run(input longint sx, sy, ncols, nrows,
			input logic [COLOR_W-1:0] col);
		out_item_t r;
		longint addr;
		addr = sy * pitch + sx;
		r.start_addr = addr[ADDR_W-1:0];
		r.run_cols = ncols[CNT_W-1:0];
		r.run_rows = nrows[CNT_W-1:0];
		r.pix_value = col;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void predict_spans(input in_item_t c);
		longint x, y, w, h, wx, wy, ww, wh, sx, sy, nc, nr;
		longint bx [4], by [4], bc [4], br [4];
		out_item_t found [4];
		int nb, n;
		x = longint'($signed(c.x_pos));
		y = longint'($signed(c.y_pos));
		w = longint'($signed(c.span_w));
		h = longint'($signed(c.span_h));
		if (c.use_clip && c.cmd != CMD_FILL) begin
			wx = win_x;
			wy = win_y;
			ww = sat_dim4k(win_w);
			wh = sat_dim4k(win_h);
		end else begin
			wx = 0;
			wy = 0;
			ww = sat_dim4k(scr_w);
			wh = sat_dim4k(scr_h);
		end
		nb = 0;
		case (c.cmd)
			CMD_HLINE: begin
				bx[0] = x; by[0] = y; bc[0] = w; br[0] = 1; nb = 1;
			end
			CMD_VLINE: begin
				bx[0] = x; by[0] = y; bc[0] = 1; br[0] = h; nb = 1;
			end
			CMD_OUTLINE: begin
				// top, bottom, left, right
				if (w > 0 && h > 0) begin
					bx = '{x, x, x, x + w - 1};
					by = '{y, y + h - 1, y, y};
					bc = '{w, w, 1, 1};
					br = '{1, 1, h, h};
					nb = 4;
				end
			end
			default: begin
				bx[0] = x; by[0] = y; bc[0] = w; br[0] = h; nb = 1;
			end
		endcase
		n = 0;
		for (int i = 0; i < nb; i++) begin
			nc = overlap(bx[i], bc[i], wx, ww, sx);
			nr = overlap(by[i], br[i], wy, wh, sy);
			if (nc > 0 && nr > 0) begin
				found[n] = make_run(sx, sy, nc, nr, c.color);
				n++;
			end
		end
		if (n > 0)
			found[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			span_fifo.push_back(found[i]);
	endfunction

	task automatic check_field(input string what, input logic [31:0] want_v, got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
				$time, what, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			scr_w = RST_SCREEN_W;
			scr_h = RST_SCREEN_H;
			pitch = RST_PITCH;
			win_x = longint'($signed(RST_CLIP_X));
			win_y = longint'($signed(RST_CLIP_Y));
			win_w = RST_CLIP_W;
			win_h = RST_CLIP_H;
			span_fifo.delete();
			fail_count = 0;
			runs_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				runs_seen++;
				if (span_fifo.size() == 0) begin
					$display("%0t: unexpected run: expected none, got addr 0x%0h %s",
						$time, out_data.start_addr, "(no command pending)");
					fail_count++;
				end else begin
					want = span_fifo.pop_front();
					check_field("start_addr", 32'(want.start_addr), 32'(out_data.start_addr));
					check_field("run_cols", 32'(want.run_cols), 32'(out_data.run_cols));
					check_field("run_rows", 32'(want.run_rows), 32'(out_data.run_rows));
					check_field("pix_value", want.pix_value, out_data.pix_value);
					check_field("last", 32'(want.last), 32'(out_data.last));
				end
			end
			if (in_valid && !in_stall)
				predict_spans(in_data);
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SCREEN_W: scr_w = cfg_wdata[DIM_REG_W-1:0];
					CFG_SCREEN_H: scr_h = cfg_wdata[DIM_REG_W-1:0];
					CFG_PITCH:    pitch = cfg_wdata[PITCH_W-1:0];
					CFG_CLIP_X:   win_x = longint'($signed(cfg_wdata[COORD_BITS-1:0]));
					CFG_CLIP_Y:   win_y = longint'($signed(cfg_wdata[COORD_BITS-1:0]));
					CFG_CLIP_W:   win_w = cfg_wdata[DIM_REG_W-1:0];
					CFG_CLIP_H:   win_h = cfg_wdata[DIM_REG_W-1:0];
					default: ;
				endcase
			end
		end
		runs_pending = span_fifo.size();
	end

endmodule

>>> tb/tb_clipped_line_rect_span_gen_top.sv
// Top of the span generator bench: clock, reset, register programming and command
// traffic under several flow-control patterns; checking lives in clrs_span_checker.
// Depends on clrs_pkg, clrs_span_checker and the DUT.
module tb_clipped_line_rect_span_gen_top;
	import clrs_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	int fail_count, runs_pending, runs_seen;
	int cmds_sent;
	int src_gap, sink_pct;
	int burst_req, burst_done, burst_len, hold_left;

	// register sets, columns in register-index order:
	// screen_w, screen_h, row_pitch, clip_x, clip_y, clip_w, clip_h
	int cfg_table [7][7] = '{
		'{640, 480, 640, 0, 0, 640, 480},
		'{64, 48, 64, 8, -4, 40, 30},
		'{320, 200, 320, 16, 8, 120, 90},
		'{8191, 8191, 16383, -32768, -32768, 8191, 8191},
		'{1, 1, 0, 32767, 32767, 0, 4096},
		'{4096, 4096, 8192, -100, 50, 4096, 1},
		'{100, 60, 128, -10, -10, 50, 40}
	};
	int cur [7];

	localparam int SRC_GAP [5]  = '{0, 46, 0, 12, 0};
	localparam int SINK_PCT [5] = '{0, 0, 46, 12, 12};

	clipped_line_rect_span_gen_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	clrs_span_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.runs_pending (runs_pending),
		.runs_seen    (runs_seen)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random stall, plus long holds on request
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		burst_done = 0;
		forever begin
			@(posedge clk);
			if (burst_done != burst_req) begin
				hold_left = burst_len;
				burst_done = burst_req;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < sink_pct);
			end
		end
	end

	function automatic int clamp_dim(input int v);
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	function automatic in_item_t cmd_item(input cmd_e op, input bit clip,
			input int x, y, w, h, input logic [COLOR_W-1:0] col);
		in_item_t it;
		it.cmd = op;
		it.use_clip = clip;
		it.x_pos = 16'(x);
		it.y_pos = 16'(y);
		it.span_w = 16'(w);
		it.span_h = 16'(h);
		it.color = col;
		return it;
	endfunction

	function automatic int rand_len(input int dim);
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return int'($urandom_range(dim / 4 + 6)) - 2;
		else if (sel < 9)
			return int'($urandom_range(dim + 40)) - 20;
		return int'($signed(16'($urandom())));
	endfunction

	// mostly commands placed around the active window, some anywhere in the coordinate space
	function automatic in_item_t rand_cmd();
		in_item_t it;
		int bx, by, bw, bh;
		it.cmd = cmd_e'($urandom_range(3));
		it.use_clip = 1'($urandom_range(1));
		it.color = $urandom();
		if (it.use_clip && it.cmd != CMD_FILL) begin
			bx = cur[CFG_CLIP_X];
			by = cur[CFG_CLIP_Y];
			bw = clamp_dim(cur[CFG_CLIP_W]);
			bh = clamp_dim(cur[CFG_CLIP_H]);
		end else begin
			bx = 0;
			by = 0;
			bw = clamp_dim(cur[CFG_SCREEN_W]);
			bh = clamp_dim(cur[CFG_SCREEN_H]);
		end
		if ($urandom_range(99) < 85) begin
			it.x_pos = 16'(bx - 12 + int'($urandom_range(bw + 24)));
			it.y_pos = 16'(by - 12 + int'($urandom_range(bh + 24)));
			it.span_w = 16'(rand_len(bw));
			it.span_h = 16'(rand_len(bh));
		end else begin
			it.x_pos = 16'($urandom());
			it.y_pos = 16'($urandom());
			it.span_w = 16'($urandom());
			it.span_h = 16'($urandom());
		end
		return it;
	endfunction

	task automatic send_cmd(input in_item_t it);
		while ($urandom_range(99) < src_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		cmds_sent++;
	endtask

	task automatic program_regs(input int set);
		for (int i = CFG_SCREEN_W; i <= CFG_CLIP_H; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= i[CFG_IDX_W-1:0];
			cfg_wdata <= CFG_W'(cfg_table[set][i]);
			@(posedge clk);
			cur[i] = cfg_table[set][i];
		end
		cfg_we <= 1'b0;
	endtask

	// drop valid, release the result side and let the pipeline run dry
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		src_gap = 0;
		sink_pct = 0;
		while ((runs_pending != 0 || hold_left != 0) && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_SCREEN_W;
		cfg_wdata = '0;
		cmds_sent = 0;
		src_gap = 0;
		sink_pct = 0;
		burst_req = 0;
		burst_len = 0;
		cur = cfg_table[0];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window: inside, partly off, empty and degenerate shapes
		send_cmd(cmd_item(CMD_HLINE, 0, 10, 20, 100, 0, 32'h1122_3344));
		send_cmd(cmd_item(CMD_HLINE, 0, 10, 20, 0, 5, 32'h0000_0001));
		send_cmd(cmd_item(CMD_HLINE, 0, 10, 20, -5, 5, 32'h0000_0002));
		send_cmd(cmd_item(CMD_HLINE, 0, -10, 479, 30, 1, 32'h0000_0003));
		send_cmd(cmd_item(CMD_HLINE, 0, 0, 480, 30, 1, 32'h0000_0004));
		send_cmd(cmd_item(CMD_VLINE, 0, 639, 470, 0, 50, 32'hA5A5_5A5A));
		send_cmd(cmd_item(CMD_VLINE, 0, 5, 5, 5, -32768, 32'h0000_0005));
		send_cmd(cmd_item(CMD_OUTLINE, 0, 5, 5, 20, 10, 32'h00FF_00FF));
		send_cmd(cmd_item(CMD_OUTLINE, 0, 0, 0, 8, 1, 32'hDEAD_BEEF));
		send_cmd(cmd_item(CMD_OUTLINE, 0, 630, 0, 1, 6, 32'hCAFE_F00D));
		send_cmd(cmd_item(CMD_OUTLINE, 0, 5, 5, 0, 6, 32'h0000_0006));
		send_cmd(cmd_item(CMD_OUTLINE, 0, -5, -5, 20, 20, 32'h1234_5678));
		send_cmd(cmd_item(CMD_FILL, 0, 100, 100, 50, 40, 32'h8765_4321));
		send_cmd(cmd_item(CMD_FILL, 1, -32768, -32768, 32767, 32767, 32'hFFFF_FFFF));
		send_cmd(cmd_item(CMD_FILL, 0, 700, 10, 20, 20, 32'h0000_0007));
		send_cmd(cmd_item(CMD_HLINE, 0, 32767, 0, 32767, 1, 32'h0000_0008));
		send_cmd(cmd_item(CMD_FILL, 0, 639, 479, 1, 1, 32'h0000_0000));
		settle();

		// small screen and a clip window straddling the top edge
		program_regs(1);
		send_cmd(cmd_item(CMD_HLINE, 1, -100, 0, 300, 1, 32'h0F0F_0F0F));
		send_cmd(cmd_item(CMD_OUTLINE, 1, 4, -6, 30, 20, 32'hF0F0_F0F0));
		send_cmd(cmd_item(CMD_FILL, 1, -5, -5, 100, 100, 32'h5555_AAAA));
		send_cmd(cmd_item(CMD_HLINE, 0, -100, 0, 300, 1, 32'hAAAA_5555));
		send_cmd(cmd_item(CMD_VLINE, 1, 7, 0, 1, 10, 32'h0000_0009));
		send_cmd(cmd_item(CMD_VLINE, 1, 47, -32768, 1, 32767, 32'h7777_7777));
		settle();

		for (int p = 0; p < 5; p++) begin
			program_regs(p + 2);
			src_gap = SRC_GAP[p];
			sink_pct = SINK_PCT[p];
			for (int k = 0; k < 54; k++) begin
				// long output hold while commands keep coming, so the queue backs up
				if (p == 4 && k == 6) begin
					burst_len = 150;
					burst_req++;
				end
				send_cmd(rand_cmd());
			end
			settle();
		end

		$display("Covered %0d commands (all four kinds, clipped and screen windows) over %0d",
			cmds_sent, 7);
		$display("register sets and five flow-control patterns; %0d runs compared", runs_seen);
		if (runs_pending != 0)
			$display("%0t: %0d expected runs never arrived", $time, runs_pending);
		if (fail_count == 0 && runs_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
